@@ hw/rtl/mcb_pkg.sv @@
// Shared constants, types and queue entry layout of the convolution block.
`default_nettype none
package mcb_pkg;

   localparam int IMG_DIM     = 4;
   localparam int IN_CHANNELS = 3;
   localparam int KERN_DIM    = 3;
   localparam int NUM_FILTERS = 2;

   localparam int OUT_SIZE  = IMG_DIM - KERN_DIM + 1;
   localparam int PIX_DEPTH = IN_CHANNELS * IMG_DIM * IMG_DIM;
   localparam int WGT_DEPTH = NUM_FILTERS * IN_CHANNELS * KERN_DIM * KERN_DIM;

   localparam int PIX_AW  = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
   localparam int WGT_AW  = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int FILT_CW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
   localparam int CHAN_CW = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
   localparam int KERN_CW = (KERN_DIM > 1) ? $clog2(KERN_DIM) : 1;
   localparam int OUT_CW  = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;

   localparam int ADDR_W0 = (PIX_AW > WGT_AW) ? PIX_AW : WGT_AW;
   localparam int ADDR_W  = (ADDR_W0 > FILT_CW) ? ADDR_W0 : FILT_CW;

   localparam int VALUE_W = 16;
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int ACC_W   = 40;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] OP_PIXEL  = 2'd0;
   localparam logic [1:0] OP_WEIGHT = 2'd1;
   localparam logic [1:0] OP_BIAS   = 2'd2;
   localparam logic [1:0] OP_RUN    = 2'd3;

   typedef enum logic [1:0] {
      KIND_PIXEL,
      KIND_WEIGHT,
      KIND_BIAS,
      KIND_RUN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [ADDR_W-1:0]         addr;
      logic signed [VALUE_W-1:0] value;
   } queue_entry_type;

   typedef struct packed {
      logic                    filter;
      logic                    row;
      logic                    col;
      logic signed [ACC_W-1:0] value;
      logic                    last;
   } result_type;

endpackage
`default_nettype wire

@@ hw/rtl/mcb_front.sv @@
// Front end: accepts request transactions, checks indices and builds queue entries.
`default_nettype none
module mcb_front (
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [23:0]              req_tdata,
   input  wire logic [1:0]               req_tuser,
   input  wire logic                     queue_full,
   output logic                          push,
   output mcb_pkg::queue_entry_type      push_entry
);

   logic       filter_idx;
   logic [1:0] chan_idx;
   logic [1:0] row_idx;
   logic [1:0] col_idx;
   logic       keep;

   assign filter_idx = req_tdata[0];
   assign chan_idx   = req_tdata[2:1];
   assign row_idx    = req_tdata[4:3];
   assign col_idx    = req_tdata[6:5];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full && keep;

   always_comb begin
      push_entry.value = req_tdata[22:7];
      push_entry.kind  = mcb_pkg::KIND_RUN;
      push_entry.addr  = '0;
      keep             = 1'b1;
      unique case (req_tuser)
         mcb_pkg::OP_PIXEL: begin
            push_entry.kind = mcb_pkg::KIND_PIXEL;
            keep = (int'(chan_idx) < mcb_pkg::IN_CHANNELS) &&
                   (int'(row_idx) < mcb_pkg::IMG_DIM) &&
                   (int'(col_idx) < mcb_pkg::IMG_DIM);
            push_entry.addr = mcb_pkg::ADDR_W'((int'(chan_idx) * mcb_pkg::IMG_DIM
                              + int'(row_idx)) * mcb_pkg::IMG_DIM + int'(col_idx));
         end
         mcb_pkg::OP_WEIGHT: begin
            push_entry.kind = mcb_pkg::KIND_WEIGHT;
            keep = (int'(filter_idx) < mcb_pkg::NUM_FILTERS) &&
                   (int'(chan_idx) < mcb_pkg::IN_CHANNELS) &&
                   (int'(row_idx) < mcb_pkg::KERN_DIM) &&
                   (int'(col_idx) < mcb_pkg::KERN_DIM);
            push_entry.addr = mcb_pkg::ADDR_W'(((int'(filter_idx) * mcb_pkg::IN_CHANNELS
                              + int'(chan_idx)) * mcb_pkg::KERN_DIM + int'(row_idx))
                              * mcb_pkg::KERN_DIM + int'(col_idx));
         end
         mcb_pkg::OP_BIAS: begin
            push_entry.kind = mcb_pkg::KIND_BIAS;
            keep = int'(filter_idx) < mcb_pkg::NUM_FILTERS;
            push_entry.addr = mcb_pkg::ADDR_W'(filter_idx);
         end
         mcb_pkg::OP_RUN: begin
            push_entry.kind = mcb_pkg::KIND_RUN;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hw/rtl/mcb_queue.sv @@
// Short command queue between the front end and the compute engine.
`default_nettype none
module mcb_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire mcb_pkg::queue_entry_type push_entry,
   output logic                          full,
   input  wire logic                     pop,
   output logic                          head_valid,
   output mcb_pkg::queue_entry_type      head_entry
);

   mcb_pkg::queue_entry_type           slot_ff [mcb_pkg::QUEUE_DEPTH];
   logic [mcb_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mcb_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mcb_pkg::QUEUE_AW:0]         count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full       = count_ff == (mcb_pkg::QUEUE_AW + 1)'(mcb_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/mcb_engine.sv @@
// Back end: holds the stores and walks the multiply-accumulate over them for a run.
`default_nettype none
module mcb_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire mcb_pkg::queue_entry_type head_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output mcb_pkg::result_type           result
);

   logic signed [mcb_pkg::VALUE_W-1:0] pix_mem [mcb_pkg::PIX_DEPTH];
   logic signed [mcb_pkg::VALUE_W-1:0] wgt_mem [mcb_pkg::WGT_DEPTH];
   logic signed [mcb_pkg::VALUE_W-1:0] bias_ff [mcb_pkg::NUM_FILTERS];

   logic                               run_ff, run_in;
   logic [mcb_pkg::KERN_CW-1:0]        kc_ff, kc_in, kr_ff, kr_in;
   logic [mcb_pkg::CHAN_CW-1:0]        k_ff, k_in;
   logic [mcb_pkg::OUT_CW-1:0]         oj_ff, oj_in, oi_ff, oi_in;
   logic [mcb_pkg::FILT_CW-1:0]        fi_ff, fi_in;

   logic                               kc_end, kr_end, k_end, oj_end, oi_end, fi_end;
   logic                               tap_first, tap_last, run_last;
   logic                               advance;
   logic                               idle;
   logic                               pix_we, wgt_we, bias_we;
   logic [mcb_pkg::PIX_AW-1:0]         pix_raddr;
   logic [mcb_pkg::WGT_AW-1:0]         wgt_raddr;

   logic signed [mcb_pkg::VALUE_W-1:0] pix_rd_ff, wgt_rd_ff;
   logic                               s1_valid_ff, s1_first_ff, s1_last_ff, s1_end_ff;
   logic [mcb_pkg::FILT_CW-1:0]        s1_fi_ff;
   logic [mcb_pkg::OUT_CW-1:0]         s1_oi_ff, s1_oj_ff;

   logic signed [mcb_pkg::PROD_W-1:0]  prod_ff;
   logic                               s2_valid_ff, s2_first_ff, s2_last_ff, s2_end_ff;
   logic [mcb_pkg::FILT_CW-1:0]        s2_fi_ff;
   logic [mcb_pkg::OUT_CW-1:0]         s2_oi_ff, s2_oj_ff;

   logic signed [mcb_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [mcb_pkg::ACC_W-1:0]   sum;
   logic                               rsp_valid_ff, rsp_valid_in;
   mcb_pkg::result_type                result_ff;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign idle    = !run_ff && !s1_valid_ff && !s2_valid_ff;
   assign pop     = idle && head_valid;
   assign pix_we  = pop && head_entry.kind == mcb_pkg::KIND_PIXEL;
   assign wgt_we  = pop && head_entry.kind == mcb_pkg::KIND_WEIGHT;
   assign bias_we = pop && head_entry.kind == mcb_pkg::KIND_BIAS;

   assign kc_end    = kc_ff == mcb_pkg::KERN_CW'(mcb_pkg::KERN_DIM - 1);
   assign kr_end    = kr_ff == mcb_pkg::KERN_CW'(mcb_pkg::KERN_DIM - 1);
   assign k_end     = k_ff == mcb_pkg::CHAN_CW'(mcb_pkg::IN_CHANNELS - 1);
   assign oj_end    = oj_ff == mcb_pkg::OUT_CW'(mcb_pkg::OUT_SIZE - 1);
   assign oi_end    = oi_ff == mcb_pkg::OUT_CW'(mcb_pkg::OUT_SIZE - 1);
   assign fi_end    = fi_ff == mcb_pkg::FILT_CW'(mcb_pkg::NUM_FILTERS - 1);
   assign tap_first = kc_ff == '0 && kr_ff == '0 && k_ff == '0;
   assign tap_last  = kc_end && kr_end && k_end;
   assign run_last  = tap_last && oj_end && oi_end && fi_end;

   assign pix_raddr = mcb_pkg::PIX_AW'((int'(k_ff) * mcb_pkg::IMG_DIM + int'(oi_ff)
                      + int'(kr_ff)) * mcb_pkg::IMG_DIM + int'(oj_ff) + int'(kc_ff));
   assign wgt_raddr = mcb_pkg::WGT_AW'(((int'(fi_ff) * mcb_pkg::IN_CHANNELS + int'(k_ff))
                      * mcb_pkg::KERN_DIM + int'(kr_ff)) * mcb_pkg::KERN_DIM
                      + int'(kc_ff));

   always_comb begin
      run_in = run_ff;
      kc_in  = kc_ff;
      kr_in  = kr_ff;
      k_in   = k_ff;
      oj_in  = oj_ff;
      oi_in  = oi_ff;
      fi_in  = fi_ff;
      if (pop && head_entry.kind == mcb_pkg::KIND_RUN) begin
         run_in = 1'b1;
         kc_in  = '0;
         kr_in  = '0;
         k_in   = '0;
         oj_in  = '0;
         oi_in  = '0;
         fi_in  = '0;
      end else if (run_ff && advance) begin
         kc_in = kc_end ? '0 : kc_ff + 1'b1;
         if (kc_end) begin
            kr_in = kr_end ? '0 : kr_ff + 1'b1;
            if (kr_end) begin
               k_in = k_end ? '0 : k_ff + 1'b1;
               if (k_end) begin
                  oj_in = oj_end ? '0 : oj_ff + 1'b1;
                  if (oj_end) begin
                     oi_in = oi_end ? '0 : oi_ff + 1'b1;
                     if (oi_end) begin
                        fi_in = fi_end ? '0 : fi_ff + 1'b1;
                     end
                  end
               end
            end
         end
         if (run_last) begin
            run_in = 1'b0;
         end
      end
   end

   always_comb begin
      sum          = (s2_first_ff ? mcb_pkg::ACC_W'(bias_ff[s2_fi_ff]) : acc_ff)
                     + mcb_pkg::ACC_W'(prod_ff);
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s2_valid_ff && s2_last_ff;
         if (s2_valid_ff) begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         kc_ff        <= '0;
         kr_ff        <= '0;
         k_ff         <= '0;
         oj_ff        <= '0;
         oi_ff        <= '0;
         fi_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         kc_ff        <= kc_in;
         kr_ff        <= kr_in;
         k_ff         <= k_in;
         oj_ff        <= oj_in;
         oi_ff        <= oi_in;
         fi_ff        <= fi_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            s1_valid_ff <= run_ff;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[head_entry.addr[mcb_pkg::PIX_AW-1:0]] <= head_entry.value;
      end
      if (advance) begin
         pix_rd_ff <= pix_mem[pix_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem[head_entry.addr[mcb_pkg::WGT_AW-1:0]] <= head_entry.value;
      end
      if (advance) begin
         wgt_rd_ff <= wgt_mem[wgt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (bias_we) begin
         bias_ff[head_entry.addr[mcb_pkg::FILT_CW-1:0]] <= head_entry.value;
      end
      acc_ff <= acc_in;
      if (advance) begin
         s1_first_ff <= tap_first;
         s1_last_ff  <= tap_last;
         s1_end_ff   <= run_last;
         s1_fi_ff    <= fi_ff;
         s1_oi_ff    <= oi_ff;
         s1_oj_ff    <= oj_ff;
         prod_ff     <= pix_rd_ff * wgt_rd_ff;
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
         s2_end_ff   <= s1_end_ff;
         s2_fi_ff    <= s1_fi_ff;
         s2_oi_ff    <= s1_oi_ff;
         s2_oj_ff    <= s1_oj_ff;
         if (s2_valid_ff && s2_last_ff) begin
            result_ff.filter <= s2_fi_ff[0];
            result_ff.row    <= s2_oi_ff[0];
            result_ff.col    <= s2_oj_ff[0];
            result_ff.value  <= sum;
            result_ff.last   <= s2_end_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

`ifndef SYNTHESIS
   a_run_starts_at_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(run_ff) |-> (kc_ff == '0 && kr_ff == '0 && k_ff == '0 &&
                         oj_ff == '0 && oi_ff == '0 && fi_ff == '0))
      else $error("run did not start at the first tap");
   a_run_pop_starts_walk: assert property (@(posedge clock) disable iff (reset)
      pop && head_entry.kind == mcb_pkg::KIND_RUN |=> run_ff)
      else $error("run command did not start the walk");
   a_element_reaches_output: assert property (@(posedge clock) disable iff (reset)
      advance && s2_valid_ff && s2_last_ff |=> rsp_valid_ff)
      else $error("finished element did not reach the output register");
   a_no_store_write_in_flight: assert property (@(posedge clock) disable iff (reset)
      (pix_we || wgt_we || bias_we) |-> !s1_valid_ff && !s2_valid_ff)
      else $error("store written while products are in flight");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/multichannel_conv2d_bias.sv @@
// Throughput: a write transaction is accepted each cycle while the four-entry queue has room.
// A run yields NUM_FILTERS*OUT_SIZE*OUT_SIZE results; each result accumulates
// IN_CHANNELS*KERN_DIM*KERN_DIM products in the single multiply-accumulate unit.
// The store read ports, the multiplier register and the accumulator form a 3-stage path.
// Reset clears queue, sequencer and output valid; the stores are undefined until written.
`default_nettype none
module multichannel_conv2d_bias (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: filter_index, channel_index[1:0], row_index[1:0],
   // col_index[1:0], value[15:0], zero pad.
   input  wire logic [23:0] req_tdata,
   // Fields from bit 0: opcode[1:0].
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: out_filter, out_row, out_col, out_value[39:0], zero pad.
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tlast
);

   logic                      queue_full;
   logic                      push;
   mcb_pkg::queue_entry_type  push_entry;
   logic                      pop;
   logic                      head_valid;
   mcb_pkg::queue_entry_type  head_entry;
   mcb_pkg::result_type       result;

   mcb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   mcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mcb_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {5'b0, result.value, result.col, result.row, result.filter};
   assign rsp_tlast = result.last;

endmodule
`default_nettype wire
